FILE: design/bti_pkg.sv
// shared types and constants of the barycentric triangle interpolator
`default_nettype none
package bti_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int PROD_W  = 34;
  localparam int DET_W   = 35;
  localparam int NUM_W   = 37;
  localparam int UNS_W   = 36;
  localparam int VAL_W   = 32;
  localparam int WGT_W   = 32;
  localparam int FRAC_W  = 24;
  localparam int QUO_W   = 32;
  localparam int DIV_LAT = QUO_W + 2;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;
  localparam int CIDX_W  = 3;

  typedef enum logic [CIDX_W-1:0] {
    IDX_AX = 3'd0,
    IDX_AY = 3'd1,
    IDX_BX = 3'd2,
    IDX_BY = 3'd3,
    IDX_CX = 3'd4,
    IDX_CY = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic signed [VAL_W-1:0]   value_a;
    logic signed [VAL_W-1:0]   value_b;
    logic signed [VAL_W-1:0]   value_c;
  } in_t;

  typedef struct packed {
    logic signed [WGT_W-1:0] weight_a;
    logic signed [WGT_W-1:0] weight_b;
    logic signed [WGT_W-1:0] weight_c;
    logic                    inside_res;
    logic                    degenerate;
    logic signed [VAL_W-1:0] interpolated;
  } out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [DIFF_W-1:0]  dybc;
    logic signed [DIFF_W-1:0]  dxcb;
    logic signed [DIFF_W-1:0]  dyca;
    logic signed [DIFF_W-1:0]  dxac;
    logic signed [DET_W-1:0]   det;
  } setup_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [VAL_W-1:0]  value_a;
    logic signed [VAL_W-1:0]  value_b;
    logic signed [VAL_W-1:0]  value_c;
  } item_t;

  // sign extension of a coordinate from its low w bits
  function automatic logic signed [COORD_W-1:0] coord_ext(input logic [COORD_W-1:0] v,
                                                          input int w);
    logic [4:0] sh;
    logic signed [COORD_W-1:0] t;
    sh = 5'(COORD_W - w);
    t = signed'(v << sh);
    return t >>> sh;
  endfunction

endpackage
`default_nettype wire

FILE: design/barycentric_triangle_interpolator.sv
// Barycentric triangle interpolator. Six configuration registers hold the
// Q12.4 triangle vertices; each input transaction carries a pixel and three
// Q16.16 attribute values and yields one result transaction with the three
// Q8.24 weights, the inside and degenerate flags and the interpolated value.
// A new transaction is taken every clock unless the full queue stalls input.
// Each of the three dividers holds a 32-stage quotient pipeline. A four-entry
// queue separates the input stage from the back pipeline; the back pipeline and
// its output register advance together whenever the output is not stalled.
// Vertex writes are not tied to transactions: the front stage reads the vertex
// registers and the back pipeline reads the setup constants as items pass.
`default_nettype none
module barycentric_triangle_interpolator #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  bti_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output bti_pkg::out_t                   out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [bti_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [15:0]                cfg_data
);

  bti_pkg::setup_t setup;
  bti_pkg::item_t  push_data, q_data;
  logic push, q_full, q_valid, pop;

  assign cfg_ready = 1'b1;

  bti_setup #(.COORD_WIDTH(COORD_WIDTH)) u_setup (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data, .setup
  );

  bti_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data, .setup,
    .push, .push_data, .q_full
  );

  bti_queue u_queue (
    .clk, .rst, .push, .push_data, .full(q_full), .q_valid, .q_data, .pop
  );

  bti_back u_back (
    .clk, .rst, .q_valid, .q_data, .pop, .setup, .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire

FILE: design/bti_setup.sv
// vertex registers and triangle setup constants
`default_nettype none
module bti_setup #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  input  wire logic [bti_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [15:0]                cfg_data,
  output bti_pkg::setup_t                 setup
);

  localparam int CW_EFF = (COORD_WIDTH < 2) ? 2 : ((COORD_WIDTH < 16) ? COORD_WIDTH : 16);

  logic [15:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [15:0] ax, ay, bx, by, cx, cy;
  logic signed [bti_pkg::DIFF_W-1:0] dybc, dxcb, dyca, dxac, dyac;
  logic signed [bti_pkg::PROD_W-1:0] prod0, prod1;
  logic signed [bti_pkg::DET_W-1:0] det;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax_r <= '0;
      ay_r <= '0;
      bx_r <= '0;
      by_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_valid) begin
      unique case (bti_pkg::cfg_idx_t'(cfg_index))
        bti_pkg::IDX_AX: ax_r <= cfg_data;
        bti_pkg::IDX_AY: ay_r <= cfg_data;
        bti_pkg::IDX_BX: bx_r <= cfg_data;
        bti_pkg::IDX_BY: by_r <= cfg_data;
        bti_pkg::IDX_CX: cx_r <= cfg_data;
        bti_pkg::IDX_CY: cy_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ax = bti_pkg::coord_ext(ax_r, CW_EFF);
  assign ay = bti_pkg::coord_ext(ay_r, CW_EFF);
  assign bx = bti_pkg::coord_ext(bx_r, CW_EFF);
  assign by = bti_pkg::coord_ext(by_r, CW_EFF);
  assign cx = bti_pkg::coord_ext(cx_r, CW_EFF);
  assign cy = bti_pkg::coord_ext(cy_r, CW_EFF);

  always_ff @(posedge clk) begin
    dybc  <= bti_pkg::DIFF_W'(by) - bti_pkg::DIFF_W'(cy);
    dxcb  <= bti_pkg::DIFF_W'(cx) - bti_pkg::DIFF_W'(bx);
    dyca  <= bti_pkg::DIFF_W'(cy) - bti_pkg::DIFF_W'(ay);
    dxac  <= bti_pkg::DIFF_W'(ax) - bti_pkg::DIFF_W'(cx);
    dyac  <= bti_pkg::DIFF_W'(ay) - bti_pkg::DIFF_W'(cy);
    prod0 <= dybc * dxac;
    prod1 <= dxcb * dyac;
    det   <= bti_pkg::DET_W'(prod0) + bti_pkg::DET_W'(prod1);
  end

  always_comb begin
    setup.cx   = cx;
    setup.cy   = cy;
    setup.dybc = dybc;
    setup.dxcb = dxcb;
    setup.dyca = dyca;
    setup.dxac = dxac;
    setup.det  = det;
  end

endmodule
`default_nettype wire

FILE: design/bti_front.sv
// input stage: takes pixels and forms offsets from the third vertex
`default_nettype none
module bti_front #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  bti_pkg::in_t       in_data,
  input  bti_pkg::setup_t    setup,
  output logic               push,
  output bti_pkg::item_t     push_data,
  input  wire logic          q_full
);

  localparam int CW_EFF = (COORD_WIDTH < 2) ? 2 : ((COORD_WIDTH < 16) ? COORD_WIDTH : 16);

  logic front_valid;
  bti_pkg::item_t front_data;
  logic signed [15:0] px, py;
  logic load;

  assign px = bti_pkg::coord_ext(in_data.pixel_x, CW_EFF);
  assign py = bti_pkg::coord_ext(in_data.pixel_y, CW_EFF);
  assign push = front_valid && !q_full;
  assign in_stall = front_valid && q_full;
  assign load = !front_valid || !q_full;
  assign push_data = front_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (load) begin
      front_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      front_data.dx      <= bti_pkg::DIFF_W'(px) - bti_pkg::DIFF_W'(setup.cx);
      front_data.dy      <= bti_pkg::DIFF_W'(py) - bti_pkg::DIFF_W'(setup.cy);
      front_data.value_a <= in_data.value_a;
      front_data.value_b <= in_data.value_b;
      front_data.value_c <= in_data.value_c;
    end
  end

endmodule
`default_nettype wire

FILE: design/bti_queue.sv
// short show-ahead queue between front and back
`default_nettype none
module bti_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  bti_pkg::item_t  push_data,
  output logic            full,
  output logic            q_valid,
  output bti_pkg::item_t  q_data,
  input  wire logic       pop
);

  bti_pkg::item_t mem [bti_pkg::Q_DEPTH];
  logic [bti_pkg::Q_AW-1:0] wr_ptr, rd_ptr;
  logic [bti_pkg::Q_AW:0] count;
  logic do_pop;

  assign full = (count == (bti_pkg::Q_AW+1)'(bti_pkg::Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_data = mem[rd_ptr];
  assign do_pop = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule
`default_nettype wire

FILE: design/bti_div.sv
// pipelined rounding divider, one quotient bit per stage, saturated q8.24 result
`default_nettype none
module bti_div (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [bti_pkg::UNS_W-1:0]  un,
  input  wire logic [bti_pkg::UNS_W-1:0]  ud,
  input  wire logic                       neg,
  output logic signed [bti_pkg::WGT_W-1:0] weight
);

  localparam int UW = bti_pkg::UNS_W;
  localparam int QW = bti_pkg::QUO_W;
  localparam int NW = UW + bti_pkg::FRAC_W + 1;
  localparam int CW = UW + QW;
  localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NEG_MIN = {1'b1, {(QW-1){1'b0}}};

  logic [NW-1:0] n_full;
  logic ovf_in;

  logic [UW-1:0] rem_s [QW+1];
  logic [QW-1:0] nlo_s [QW+1];
  logic [QW-1:0] q_s   [QW+1];
  logic [UW-1:0] ud_s  [QW+1];
  logic          neg_s [QW+1];
  logic          ovf_s [QW+1];

  assign n_full = NW'({un, {bti_pkg::FRAC_W{1'b0}}}) + NW'(ud >> 1);
  assign ovf_in = CW'(n_full) >= {ud, {QW{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= UW'(n_full[NW-1:QW]);
      nlo_s[0] <= n_full[QW-1:0];
      q_s[0]   <= '0;
      ud_s[0]  <= ud;
      neg_s[0] <= neg;
      ovf_s[0] <= ovf_in;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [UW:0] t;
    logic [UW:0] d;
    logic ge;
    assign t = {rem_s[k], nlo_s[k][QW-1]};
    assign d = t - {1'b0, ud_s[k]};
    assign ge = t >= {1'b0, ud_s[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? d[UW-1:0] : t[UW-1:0];
        nlo_s[k+1] <= nlo_s[k] << 1;
        q_s[k+1]   <= {q_s[k][QW-2:0], ge};
        ud_s[k+1]  <= ud_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      priority if (ovf_s[QW]) begin
        weight <= neg_s[QW] ? NEG_MIN : POS_MAX;
      end else if (neg_s[QW]) begin
        weight <= (q_s[QW] > NEG_MIN) ? NEG_MIN : (~q_s[QW] + 1'b1);
      end else begin
        weight <= (q_s[QW] > POS_MAX) ? POS_MAX : q_s[QW];
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/bti_back.sv
// back pipeline: numerators, division, weighting and output register
`default_nettype none
module bti_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  bti_pkg::item_t   q_data,
  output logic             pop,
  input  bti_pkg::setup_t  setup,
  output logic             out_valid,
  input  wire logic        out_stall,
  output bti_pkg::out_t    out_data
);

  localparam int LAT = bti_pkg::DIV_LAT;
  localparam int SW  = 2 * bti_pkg::VAL_W + 2;
  localparam int HW  = SW - bti_pkg::FRAC_W;

  typedef struct packed {
    logic signed [bti_pkg::VAL_W-1:0] value_a;
    logic signed [bti_pkg::VAL_W-1:0] value_b;
    logic signed [bti_pkg::VAL_W-1:0] value_c;
    logic                             degen;
  } side_t;

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign pop = adv;

  // products
  logic v1;
  logic signed [bti_pkg::PROD_W-1:0] pa0, pa1, pb0, pb1;
  logic signed [bti_pkg::VAL_W-1:0] va1, vb1, vc1;

  always_ff @(posedge clk) begin
    if (adv) begin
      pa0 <= q_data.dx * setup.dybc;
      pa1 <= q_data.dy * setup.dxcb;
      pb0 <= q_data.dx * setup.dyca;
      pb1 <= q_data.dy * setup.dxac;
      va1 <= q_data.value_a;
      vb1 <= q_data.value_b;
      vc1 <= q_data.value_c;
    end
  end

  // numerators
  logic v2;
  logic signed [bti_pkg::NUM_W-1:0] na2, nb2, nc2, det2;
  logic degen2;
  logic signed [bti_pkg::VAL_W-1:0] va2, vb2, vc2;
  logic signed [bti_pkg::NUM_W-1:0] na_sum, nb_sum, det_ext;

  assign na_sum  = bti_pkg::NUM_W'(pa0) + bti_pkg::NUM_W'(pa1);
  assign nb_sum  = bti_pkg::NUM_W'(pb0) + bti_pkg::NUM_W'(pb1);
  assign det_ext = bti_pkg::NUM_W'(setup.det);

  always_ff @(posedge clk) begin
    if (adv) begin
      na2    <= na_sum;
      nb2    <= nb_sum;
      nc2    <= det_ext - na_sum - nb_sum;
      det2   <= det_ext;
      degen2 <= (setup.det == '0);
      va2    <= va1;
      vb2    <= vb1;
      vc2    <= vc1;
    end
  end

  // magnitudes and signs
  logic v3;
  logic [bti_pkg::UNS_W-1:0] ua3, ub3, uc3, ud3;
  logic neg_a3, neg_b3, neg_c3;
  side_t side3;
  logic sd;
  logic signed [bti_pkg::NUM_W-1:0] abs_a, abs_b, abs_c, abs_d;

  assign sd = det2[bti_pkg::NUM_W-1];
  assign abs_a = na2[bti_pkg::NUM_W-1] ? -na2 : na2;
  assign abs_b = nb2[bti_pkg::NUM_W-1] ? -nb2 : nb2;
  assign abs_c = nc2[bti_pkg::NUM_W-1] ? -nc2 : nc2;
  assign abs_d = sd ? -det2 : det2;

  always_ff @(posedge clk) begin
    if (adv) begin
      ua3    <= abs_a[bti_pkg::UNS_W-1:0];
      ub3    <= abs_b[bti_pkg::UNS_W-1:0];
      uc3    <= abs_c[bti_pkg::UNS_W-1:0];
      ud3    <= abs_d[bti_pkg::UNS_W-1:0];
      neg_a3 <= na2[bti_pkg::NUM_W-1] ^ sd;
      neg_b3 <= nb2[bti_pkg::NUM_W-1] ^ sd;
      neg_c3 <= nc2[bti_pkg::NUM_W-1] ^ sd;
      side3  <= '{value_a: va2, value_b: vb2, value_c: vc2, degen: degen2};
    end
  end

  // dividers
  logic signed [bti_pkg::WGT_W-1:0] wd_a, wd_b, wd_c;

  bti_div u_div_a (.clk, .en(adv), .un(ua3), .ud(ud3), .neg(neg_a3), .weight(wd_a));
  bti_div u_div_b (.clk, .en(adv), .un(ub3), .ud(ud3), .neg(neg_b3), .weight(wd_b));
  bti_div u_div_c (.clk, .en(adv), .un(uc3), .ud(ud3), .neg(neg_c3), .weight(wd_c));

  side_t side_s [1:LAT];
  logic  vs_s   [1:LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      side_s[1] <= side3;
      for (int k = 2; k <= LAT; k++) side_s[k] <= side_s[k-1];
    end
  end

  // weighting
  logic v4;
  logic signed [bti_pkg::WGT_W-1:0] wa4, wb4, wc4;
  logic signed [2*bti_pkg::VAL_W-1:0] p_a4, p_b4, p_c4;
  logic inside4, degen4;
  logic signed [bti_pkg::WGT_W-1:0] wa, wb, wc;
  side_t sl;

  assign sl = side_s[LAT];
  assign wa = sl.degen ? '0 : wd_a;
  assign wb = sl.degen ? '0 : wd_b;
  assign wc = sl.degen ? '0 : wd_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      wa4     <= wa;
      wb4     <= wb;
      wc4     <= wc;
      p_a4    <= sl.value_a * wa;
      p_b4    <= sl.value_b * wb;
      p_c4    <= sl.value_c * wc;
      inside4 <= !sl.degen && !wa[bti_pkg::WGT_W-1] && !wb[bti_pkg::WGT_W-1]
                 && !wc[bti_pkg::WGT_W-1];
      degen4  <= sl.degen;
    end
  end

  // rounded sum
  logic v5;
  logic signed [SW-1:0] sum5;
  logic signed [bti_pkg::WGT_W-1:0] wa5, wb5, wc5;
  logic inside5, degen5;

  always_ff @(posedge clk) begin
    if (adv) begin
      sum5    <= SW'(p_a4) + SW'(p_b4) + SW'(p_c4)
                 + SW'(signed'({1'b0, 1'b1, {(bti_pkg::FRAC_W-1){1'b0}}}));
      wa5     <= wa4;
      wb5     <= wb4;
      wc5     <= wc4;
      inside5 <= inside4;
      degen5  <= degen4;
    end
  end

  // saturation into the output register
  logic [HW-1:0] hi5;
  logic fits;
  logic [bti_pkg::VAL_W-1:0] res;

  assign hi5 = sum5[SW-1:bti_pkg::FRAC_W];
  assign fits = (hi5[HW-1:bti_pkg::VAL_W-1] == '0) || (hi5[HW-1:bti_pkg::VAL_W-1] == '1);
  assign res = fits ? hi5[bti_pkg::VAL_W-1:0]
                    : (hi5[HW-1] ? {1'b1, {(bti_pkg::VAL_W-1){1'b0}}}
                                 : {1'b0, {(bti_pkg::VAL_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.weight_a     <= wa5;
      out_data.weight_b     <= wb5;
      out_data.weight_c     <= wc5;
      out_data.inside_res   <= inside5;
      out_data.degenerate   <= degen5;
      out_data.interpolated <= res;
    end
  end

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 1; k <= LAT; k++) vs_s[k] <= 1'b0;
    end else if (adv) begin
      v1        <= q_valid;
      v2        <= v1;
      v3        <= v2;
      vs_s[1]   <= v3;
      for (int k = 2; k <= LAT; k++) vs_s[k] <= vs_s[k-1];
      v4        <= vs_s[LAT];
      v5        <= v4;
      out_valid <= v5;
    end
  end

endmodule
`default_nettype wire

FILE: dv/barycentric_triangle_interpolator_tb.sv
// self-checking testbench for the barycentric triangle interpolator
`default_nettype none
module barycentric_triangle_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  bti_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bti_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bti_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  barycentric_triangle_interpolator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic signed [15:0] vtx [6];
  bti_pkg::in_t  pixel_q [$];
  bti_pkg::out_t weights_q [$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   sent = 0;
  int   got = 0;
  int   inside_seen = 0;
  int   degen_seen = 0;
  bit   hold_long = 1'b0;
  bit   feeding = 1'b0;

  function automatic longint rnd_div(longint n, longint d);
    logic neg;
    longint un, ud, q;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = ((un <<< 24) + ud / 2) / ud;
    if (neg) return (q > 64'sd2147483648) ? -64'sd2147483648 : -q;
    return (q > 64'sd2147483647) ? 64'sd2147483647 : q;
  endfunction

  function automatic longint floor24(longint p);
    return p >>> 24;
  endfunction

  function automatic bti_pkg::out_t interpolate(bti_pkg::in_t it);
    bti_pkg::out_t r;
    longint ax, ay, bx, by, cx, cy, px, py, det, na, nb, wa, wb, wc;
    longint p0, p1, p2, hi, lo, res;
    r = '0;
    ax = vtx[0]; ay = vtx[1]; bx = vtx[2]; by = vtx[3]; cx = vtx[4]; cy = vtx[5];
    px = it.pixel_x; py = it.pixel_y;
    det = (by - cy) * (ax - cx) + (cx - bx) * (ay - cy);
    r.degenerate = (det == 0);
    if (det != 0) begin
      na = (px - cx) * (by - cy) + (py - cy) * (cx - bx);
      nb = (px - cx) * (cy - ay) + (py - cy) * (ax - cx);
      wa = rnd_div(na, det);
      wb = rnd_div(nb, det);
      wc = rnd_div(det - na - nb, det);
      r.weight_a = wa[31:0];
      r.weight_b = wb[31:0];
      r.weight_c = wc[31:0];
      r.inside_res = wa >= 0 && wb >= 0 && wc >= 0;
      p0 = longint'(it.value_a) * wa;
      p1 = longint'(it.value_b) * wb;
      p2 = longint'(it.value_c) * wc;
      hi = floor24(p0) + floor24(p1) + floor24(p2);
      lo = (p0 - (floor24(p0) <<< 24)) + (p1 - (floor24(p1) <<< 24))
         + (p2 - (floor24(p2) <<< 24));
      res = hi + floor24(lo + (64'sd1 <<< 23));
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      r.interpolated = res[31:0];
    end
    return r;
  endfunction

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      weights_q.push_back(interpolate(in_data));
      sent++;
      if (in_gap == 0 && pixel_q.size() > 0) begin
        in_data <= pixel_q.pop_front();
        in_gap = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && pixel_q.size() > 0 && feeding) begin
      if (in_gap > 0) begin
        in_gap--;
      end else begin
        in_valid <= 1'b1;
        in_data <= pixel_q.pop_front();
        in_gap = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
      end
    end
  end

  // monitor
  int out_gap = 0;
  int hold_count = 0;
  always @(posedge clk) begin
    bti_pkg::out_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        got++;
        if (weights_q.size() == 0) begin
          $error("result transaction with no expected result");
          errors++;
        end else begin
          e = weights_q.pop_front();
          if (out_data.inside_res) inside_seen++;
          if (out_data.degenerate) degen_seen++;
          if (out_data.weight_a !== e.weight_a) begin
            $error("weight_a exp %0d got %0d", e.weight_a, out_data.weight_a); errors++;
          end
          if (out_data.weight_b !== e.weight_b) begin
            $error("weight_b exp %0d got %0d", e.weight_b, out_data.weight_b); errors++;
          end
          if (out_data.weight_c !== e.weight_c) begin
            $error("weight_c exp %0d got %0d", e.weight_c, out_data.weight_c); errors++;
          end
          if (out_data.inside_res !== e.inside_res) begin
            $error("inside_res exp %0b got %0b", e.inside_res, out_data.inside_res);
            errors++;
          end
          if (out_data.degenerate !== e.degenerate) begin
            $error("degenerate exp %0b got %0b", e.degenerate, out_data.degenerate);
            errors++;
          end
          if (out_data.interpolated !== e.interpolated) begin
            $error("interpolated exp %0d got %0d", e.interpolated, out_data.interpolated);
            errors++;
          end
        end
      end else if (in_valid && !in_stall) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (hold_long) begin
        hold_count++;
        out_stall <= hold_count < 200;
        if (hold_count >= 200) hold_long = 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall)
          out_gap = $urandom_range(3) == 0 ? 0 : $urandom_range(12);
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_vertex(bti_pkg::cfg_idx_t idx, logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    vtx[idx] = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic set_triangle(logic [15:0] ax, ay, bx, by, cx, cy);
    write_vertex(bti_pkg::IDX_AX, ax); write_vertex(bti_pkg::IDX_AY, ay);
    write_vertex(bti_pkg::IDX_BX, bx); write_vertex(bti_pkg::IDX_BY, by);
    write_vertex(bti_pkg::IDX_CX, cx); write_vertex(bti_pkg::IDX_CY, cy);
  endtask

  task automatic run_pixels();
    feeding = 1'b1;
    wait (pixel_q.size() == 0 && !in_valid && weights_q.size() == 0);
    feeding = 1'b0;
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic bti_pkg::in_t rand_pixel(int span);
    bti_pkg::in_t it;
    it.pixel_x = span ? 16'($signed($urandom_range(2 * span)) - span) : 16'($urandom);
    it.pixel_y = span ? 16'($signed($urandom_range(2 * span)) - span) : 16'($urandom);
    case ($urandom_range(3))
      0: begin it.value_a = $urandom; it.value_b = $urandom; it.value_c = $urandom; end
      default: begin
        it.value_a = $signed($urandom_range(1 << 22)) - (1 << 21);
        it.value_b = $signed($urandom_range(1 << 22)) - (1 << 21);
        it.value_c = $signed($urandom_range(1 << 22)) - (1 << 21);
      end
    endcase
    return it;
  endfunction

  function automatic logic [15:0] rcoord(int span);
    return span ? 16'($signed($urandom_range(2 * span)) - span) : 16'($urandom);
  endfunction

  initial begin
    bti_pkg::in_t it;
    int span;
    foreach (vtx[i]) vtx[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset triangle is degenerate
    it = '0; it.value_a = 32'h7fffffff; pixel_q.push_back(it);
    it.pixel_x = 16'h8000; it.pixel_y = 16'h7fff; pixel_q.push_back(it);
    run_pixels();

    // extreme triangle with corner pixels and extreme values
    set_triangle(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    foreach (vtx[i]) begin
      it.pixel_x = (i & 1) ? 16'h7fff : 16'h8000;
      it.pixel_y = (i & 2) ? 16'h7fff : 16'h8000;
      it.value_a = (i & 1) ? 32'h7fffffff : 32'h80000000;
      it.value_b = (i & 2) ? 32'h7fffffff : 32'h80000000;
      it.value_c = (i & 4) ? 32'h80000000 : 32'h7fffffff;
      pixel_q.push_back(it);
    end
    run_pixels();

    // tiny triangle so weights saturate, plus pixels on vertices
    set_triangle(16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
    it = '0; it.value_a = 32'h7fffffff; it.value_b = 32'h7fffffff;
    it.value_c = 32'h7fffffff; pixel_q.push_back(it);
    it.pixel_x = 16'd1; pixel_q.push_back(it);
    it.pixel_x = 16'h7fff; it.pixel_y = 16'h7fff; pixel_q.push_back(it);
    it.pixel_x = 16'h8000; it.pixel_y = 16'h8000; pixel_q.push_back(it);
    it.pixel_x = 16'h8000; it.pixel_y = 16'h7fff;
    it.value_a = 32'h80000000; pixel_q.push_back(it);
    run_pixels();

    // long receiver hold while the sender keeps offering
    set_triangle(16'd0, 16'd0, 16'd320, 16'd0, 16'd0, 16'd320);
    repeat (60) pixel_q.push_back(rand_pixel(400));
    hold_count = 0;
    hold_long = 1'b1;
    run_pixels();

    for (int phase = 0; phase < 34; phase++) begin
      span = (phase % 4 == 0) ? 0 : (phase % 4 == 1) ? 64 : (phase % 4 == 2) ? 1024 : 8000;
      if (phase % 9 == 8)
        set_triangle(16'd16, 16'd16, 16'd16, 16'd16, 16'd48, 16'd48);
      else
        set_triangle(rcoord(span), rcoord(span), rcoord(span),
                     rcoord(span), rcoord(span), rcoord(span));
      repeat (50) pixel_q.push_back(rand_pixel(span == 0 ? 0 : span + span / 4));
      run_pixels();
    end

    $display("sent %0d pixels, checked %0d results (%0d inside, %0d degenerate)",
             sent, got, inside_seen, degen_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: barycentric_triangle_interpolator.f
design/bti_pkg.sv
design/bti_setup.sv
design/bti_front.sv
design/bti_queue.sv
design/bti_div.sv
design/bti_back.sv
design/barycentric_triangle_interpolator.sv
dv/barycentric_triangle_interpolator_tb.sv
